@@ design/dual_interval_timer_irq_assert.svh @@
// Assertion macros for the dual interval timer block.
// Included by the top-level module, which checks its own logic; needs no package.
`ifndef DUAL_INTERVAL_TIMER_IRQ_ASSERT_SVH
`define DUAL_INTERVAL_TIMER_IRQ_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DIT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dit_pkg.sv @@
// Shared constants for the dual interval timer: register indexes,
// control bit positions, flag bits and field widths. No dependencies.
package dit_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegCtlA   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCtlB   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMask   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegReloadA = 3'd3;
  localparam logic [CfgIdxW-1:0] RegReloadB = 3'd4;

  // Control register bit positions.
  localparam int unsigned CtlStart   = 0;
  localparam int unsigned CtlToggle  = 1;
  localparam int unsigned CtlPulse   = 2;
  localparam int unsigned CtlOneShot = 3;
  localparam int unsigned CtlCntSrc  = 5;
  localparam int unsigned CtlSerial  = 6;

  // Timer B source select, control_b bits 6:5.
  localparam logic [1:0] SrcCycles  = 2'b00;
  localparam logic [1:0] SrcChained = 2'b10;

  // Flag and mask bit positions.
  localparam int unsigned FlagA      = 0;
  localparam int unsigned FlagB      = 1;
  localparam int unsigned FlagAlarm  = 2;
  localparam int unsigned FlagSerial = 3;
  localparam int unsigned FlagAny    = 7;

endpackage

@@ design/dual_interval_timer_irq.sv @@
// Dual interval timer with interrupt flag latch, top level.
// Depends on dit_pkg and dual_interval_timer_irq_assert.svh.
//
// Usage: each input item is one tick (elapsed cycles, alarm event, flag
// clear, serial count load). Every accepted item yields exactly one result
// item: irq, the flag latch after the tick and the two port B toggle levels.
// Both channels use valid/stall; an item moves on an edge where valid is
// high and stall is low.
// An item accepted at one edge is taken into the input register and
// processed while it is held there; the result is loaded into the result
// register, as the timer and flag state is updated, when that register is
// free or being emptied. Throughput is one item per clock while the
// receiver does not stall. When the receiver stalls, the result register
// holds its item and the input register can still take one more item;
// only then is in_stall_o raised. Reset clears all timer state, both
// toggle levels go high, and all configuration registers clear. The user
// must write configuration through cfg_we_i / cfg_idx_i / cfg_data_i
// only while no item is in flight; the block itself does not enforce
// this.
module dual_interval_timer_irq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dit_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dit_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    elapsed_cycles_i,
  input  logic                          alarm_event_i,
  input  logic                          clear_flags_i,
  input  logic                          serial_load_i,
  input  logic [7:0]                    serial_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          irq_o,
  output logic [7:0]                    flag_latch_o,
  output logic                          port_b6_o,
  output logic                          port_b7_o
);

  // Configuration registers.
  logic [7:0]  ctl_a_q, ctl_b_q;
  logic [4:0]  mask_q;
  logic [15:0] reload_a_q, reload_b_q;

  // Timer state.
  logic [15:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [7:0]  flags_q, flags_d;
  logic        a_uflow_q, a_uflow_d;
  logic [7:0]  ser_bits_q, ser_bits_d, ser_pend_q, ser_pend_d;
  logic        tog6_q, tog6_d, tog7_q, tog7_d;

  // Input register.
  logic        s_valid_q;
  logic [7:0]  s_dt_q, s_scount_q;
  logic        s_alarm_q, s_clr_q, s_sload_q;

  // Result register.
  logic        out_valid_q;
  logic        r_irq_q, r_irq_d;

  logic in_acc, adv;

  // The input register advances whenever the result register is free or
  // being emptied in this cycle.
  assign adv        = s_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q    <= '0;
      ctl_b_q    <= '0;
      mask_q     <= '0;
      reload_a_q <= '0;
      reload_b_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dit_pkg::RegCtlA:    ctl_a_q    <= cfg_data_i[7:0];
        dit_pkg::RegCtlB:    ctl_b_q    <= cfg_data_i[7:0];
        dit_pkg::RegMask:    mask_q     <= cfg_data_i[4:0];
        dit_pkg::RegReloadA: reload_a_q <= cfg_data_i;
        dit_pkg::RegReloadB: reload_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_acc) begin
      s_valid_q <= 1'b1;
    end else if (adv) begin
      s_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_dt_q     <= elapsed_cycles_i;
      s_alarm_q  <= alarm_event_i;
      s_clr_q    <= clear_flags_i;
      s_sload_q  <= serial_load_i;
      s_scount_q <= serial_count_i;
    end
  end

  // One tick: flag clear, serial load, alarm, timer A, then timer B.
  always_comb begin
    logic [1:0] src_b;
    logic       b_run;
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    flags_d    = s_clr_q ? 8'h00 : flags_q;
    a_uflow_d  = a_uflow_q;
    ser_bits_d = ser_bits_q;
    ser_pend_d = ser_pend_q;
    tog6_d     = tog6_q;
    tog7_d     = tog7_q;
    r_irq_d    = 1'b0;
    src_b      = ctl_b_q[6:5];
    b_run      = 1'b0;

    if (s_sload_q) begin
      if (ser_bits_q == 8'h00) begin
        ser_bits_d = s_scount_q;
      end else begin
        ser_pend_d = s_scount_q;
      end
    end

    if (s_alarm_q) begin
      flags_d[dit_pkg::FlagAlarm] = 1'b1;
      if (mask_q[dit_pkg::FlagAlarm]) begin
        flags_d[dit_pkg::FlagAny] = 1'b1;
        r_irq_d = 1'b1;
      end
    end

    if (ctl_a_q[dit_pkg::CtlStart] && !ctl_a_q[dit_pkg::CtlCntSrc]) begin
      cnt_a_d = (cnt_a_q > {8'h00, s_dt_q}) ? cnt_a_q - {8'h00, s_dt_q} : 16'h0000;
      if (cnt_a_d == 16'h0000) begin
        a_uflow_d = 1'b1;
        if (ctl_a_q[dit_pkg::CtlToggle] && !ctl_a_q[dit_pkg::CtlPulse]) begin
          tog6_d = !tog6_q;
        end
        flags_d[dit_pkg::FlagA] = 1'b1;
        if (!ctl_a_q[dit_pkg::CtlOneShot]) begin
          cnt_a_d = reload_a_q;
        end
        if (mask_q[dit_pkg::FlagA]) begin
          flags_d[dit_pkg::FlagAny] = 1'b1;
          r_irq_d = 1'b1;
        end
        if (ctl_a_q[dit_pkg::CtlSerial] && ser_bits_d != 8'h00) begin
          ser_bits_d = ser_bits_d - 8'd1;
          if (ser_bits_d == 8'h00) begin
            flags_d[dit_pkg::FlagSerial] = 1'b1;
            if (mask_q[dit_pkg::FlagSerial]) begin
              flags_d[dit_pkg::FlagAny] = 1'b1;
              r_irq_d = 1'b1;
            end
            if (ser_pend_d != 8'h00) begin
              ser_bits_d = ser_pend_d;
              ser_pend_d = 8'h00;
            end
          end
        end
      end
    end

    if (ctl_b_q[dit_pkg::CtlStart]) begin
      if (src_b == dit_pkg::SrcCycles) begin
        b_run   = 1'b1;
        cnt_b_d = (cnt_b_q > {8'h00, s_dt_q}) ? cnt_b_q - {8'h00, s_dt_q} : 16'h0000;
      end else if (src_b == dit_pkg::SrcChained) begin
        b_run = 1'b1;
        if (a_uflow_d) begin
          a_uflow_d = 1'b0;
          cnt_b_d   = cnt_b_q - 16'd1;
        end
      end
    end

    if (b_run && cnt_b_d == 16'h0000) begin
      if (ctl_b_q[dit_pkg::CtlToggle] && !ctl_b_q[dit_pkg::CtlPulse]) begin
        tog7_d = !tog7_q;
      end
      flags_d[dit_pkg::FlagB] = 1'b1;
      if (!ctl_b_q[dit_pkg::CtlOneShot]) begin
        cnt_b_d = reload_b_q;
      end
      if (mask_q[dit_pkg::FlagB]) begin
        flags_d[dit_pkg::FlagAny] = 1'b1;
        r_irq_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      flags_q    <= '0;
      a_uflow_q  <= 1'b0;
      ser_bits_q <= '0;
      ser_pend_q <= '0;
      tog6_q     <= 1'b1;
      tog7_q     <= 1'b1;
    end else if (adv) begin
      cnt_a_q    <= cnt_a_d;
      cnt_b_q    <= cnt_b_d;
      flags_q    <= flags_d;
      a_uflow_q  <= a_uflow_d;
      ser_bits_q <= ser_bits_d;
      ser_pend_q <= ser_pend_d;
      tog6_q     <= tog6_d;
      tog7_q     <= tog7_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Flags and toggle levels are shown straight from the state registers,
  // which only change when a new result is loaded.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_irq_q <= r_irq_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign irq_o        = r_irq_q;
  assign flag_latch_o = flags_q;
  assign port_b6_o    = tog6_q;
  assign port_b7_o    = tog7_q;

`include "dual_interval_timer_irq_assert.svh"

  `DIT_ASSERT_NEXT(a_adv_fills_out, clk_i, rst_ni, adv, out_valid_q, "result register not loaded")
  `DIT_ASSERT_NOW(a_stall_needs_item, clk_i, rst_ni, in_stall_o, s_valid_q && out_valid_q, "stall without a held item")
  `DIT_ASSERT_NOW(a_irq_sets_any, clk_i, rst_ni, out_valid_q && r_irq_q, flags_q[dit_pkg::FlagAny], "irq without any-flag")
  `DIT_ASSERT_NEXT(a_pulse_no_toggle, clk_i, rst_ni, adv && ctl_a_q[dit_pkg::CtlPulse], $stable(tog6_q), "port b6 toggled in pulse mode")

endmodule

@@ dv/dual_interval_timer_irq_tb.sv @@
// Self-checking testbench for dual_interval_timer_irq: directed and random ticks
// under random stalls, checked against a cycle-free tick predictor.
// Depends on dit_pkg and the dual_interval_timer_irq RTL only.
module dual_interval_timer_irq_tb;
  import dit_pkg::*;

  localparam int unsigned HoldOffCycles  = 300;
  localparam int unsigned WatchdogLimit  = 4000;
  localparam int unsigned EndSettle      = 20;
  localparam int unsigned ItemsPerPhase  = 90;
  localparam int unsigned NumPhases      = 11;
  localparam int unsigned MaxPrinted     = 100;

  // Timer B sources that count the CNT pin; the timer halts in both.
  localparam logic [1:0] SrcCntPulses  = 2'b01;
  localparam logic [1:0] SrcCntChained = 2'b11;

  typedef struct packed {
    logic       irq;
    logic [7:0] flags;
    logic       b6;
    logic       b7;
  } tick_result_t;

  class timer_irq_scoreboard;
    logic [7:0]   ctl_a, ctl_b;
    logic [4:0]   mask;
    logic [15:0]  rel_a, rel_b;
    logic [15:0]  cnt_a, cnt_b;
    logic [7:0]   flags;
    logic         a_uf;
    logic [7:0]   ser_bits, ser_pend;
    logic         tog6, tog7;
    tick_result_t tick_results_q[$];
    int unsigned  mismatches;

    function new();
      ctl_a = '0; ctl_b = '0; mask = '0; rel_a = '0; rel_b = '0;
      cnt_a = '0; cnt_b = '0; flags = '0; a_uf = 1'b0;
      ser_bits = '0; ser_pend = '0;
      tog6 = 1'b1; tog7 = 1'b1;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegCtlA:    ctl_a = data[7:0];
        RegCtlB:    ctl_b = data[7:0];
        RegMask:    mask  = data[4:0];
        RegReloadA: rel_a = data;
        RegReloadB: rel_b = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return tick_results_q.size();
    endfunction

    // Work out the outcome of one accepted tick and queue it.
    function void note_tick(logic [7:0] dt, logic alarm, logic clr, logic sload,
                            logic [7:0] scount);
      tick_result_t res;
      logic         irq;
      logic [1:0]   src;
      irq = 1'b0;
      src = ctl_b[CtlSerial:CtlCntSrc];
      if (clr) flags = '0;
      if (sload) begin
        if (ser_bits == 0) ser_bits = scount;
        else ser_pend = scount;
      end
      if (alarm) begin
        flags[FlagAlarm] = 1'b1;
        if (mask[FlagAlarm]) begin
          flags[FlagAny] = 1'b1;
          irq = 1'b1;
        end
      end
      if (ctl_a[CtlStart] && !ctl_a[CtlCntSrc]) begin
        cnt_a = (cnt_a > 16'(dt)) ? cnt_a - 16'(dt) : '0;
        if (cnt_a == 0) begin
          a_uf = 1'b1;
          if (ctl_a[CtlToggle] && !ctl_a[CtlPulse]) tog6 = !tog6;
          flags[FlagA] = 1'b1;
          if (!ctl_a[CtlOneShot]) cnt_a = rel_a;
          if (mask[FlagA]) begin
            flags[FlagAny] = 1'b1;
            irq = 1'b1;
          end
          if (ctl_a[CtlSerial] && ser_bits != 0) begin
            ser_bits = ser_bits - 8'd1;
            if (ser_bits == 0) begin
              flags[FlagSerial] = 1'b1;
              if (mask[FlagSerial]) begin
                flags[FlagAny] = 1'b1;
                irq = 1'b1;
              end
              if (ser_pend != 0) begin
                ser_bits = ser_pend;
                ser_pend = '0;
              end
            end
          end
        end
      end
      if (ctl_b[CtlStart] && (src == SrcCycles || src == SrcChained)) begin
        if (src == SrcCycles) begin
          cnt_b = (cnt_b > 16'(dt)) ? cnt_b - 16'(dt) : '0;
        end else if (a_uf) begin
          // A chained count of zero wraps around rather than saturating.
          a_uf = 1'b0;
          cnt_b = cnt_b - 16'd1;
        end
        if (cnt_b == 0) begin
          if (ctl_b[CtlToggle] && !ctl_b[CtlPulse]) tog7 = !tog7;
          flags[FlagB] = 1'b1;
          if (!ctl_b[CtlOneShot]) cnt_b = rel_b;
          if (mask[FlagB]) begin
            flags[FlagAny] = 1'b1;
            irq = 1'b1;
          end
        end
      end
      res.irq = irq;
      res.flags = flags;
      res.b6 = tog6;
      res.b7 = tog7;
      tick_results_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MaxPrinted) $display("%0t ERROR: %s", $time, msg);
      mismatches++;
    endtask

    task check_outcome(logic irq, logic [7:0] fl, logic b6, logic b7);
      tick_result_t want;
      if (tick_results_q.size() == 0) begin
        report_mismatch("result item with no tick outstanding");
        return;
      end
      want = tick_results_q.pop_front();
      if (irq !== want.irq)
        report_mismatch($sformatf("irq got %b want %b", irq, want.irq));
      if (fl !== want.flags)
        report_mismatch($sformatf("flag_latch got %h want %h", fl, want.flags));
      if (b6 !== want.b6)
        report_mismatch($sformatf("port_b6 got %b want %b", b6, want.b6));
      if (b7 !== want.b7)
        report_mismatch($sformatf("port_b7 got %b want %b", b7, want.b7));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          elapsed_cycles_i;
  logic                alarm_event_i;
  logic                clear_flags_i;
  logic                serial_load_i;
  logic [7:0]          serial_count_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                irq_o;
  logic [7:0]          flag_latch_o;
  logic                port_b6_o;
  logic                port_b7_o;

  timer_irq_scoreboard sb = new();
  int unsigned         idle_cycles = 0;
  bit                  idling_on = 1'b0;
  bit                  hold_off_req = 1'b0;

  dual_interval_timer_irq u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .elapsed_cycles_i,
    .alarm_event_i,
    .clear_flags_i,
    .serial_load_i,
    .serial_count_i,
    .out_valid_o,
    .out_stall_i,
    .irq_o,
    .flag_latch_o,
    .port_b6_o,
    .port_b7_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Control word; upper holds bits 6:5 (serial and CNT for A, source for B).
  function automatic logic [7:0] ctl_word(logic start, logic toggle, logic pulse,
                                          logic one_shot, logic [1:0] upper);
    logic [7:0] w;
    w = '0;
    w[CtlStart] = start;
    w[CtlToggle] = toggle;
    w[CtlPulse] = pulse;
    w[CtlOneShot] = one_shot;
    w[CtlSerial:CtlCntSrc] = upper;
    return w;
  endfunction

  function automatic logic [15:0] pick_reload();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(0, 40));
    else if (r < 8) return 16'($urandom_range(41, 1500));
    else if (r < 9) return 16'($urandom_range(0, 65535));
    else return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic program_regs(logic [7:0] ca, logic [7:0] cb, logic [4:0] msk,
                              logic [15:0] ra, logic [15:0] rb);
    write_reg(RegCtlA, 16'(ca));
    write_reg(RegCtlB, 16'(cb));
    write_reg(RegMask, 16'(msk));
    write_reg(RegReloadA, ra);
    write_reg(RegReloadB, rb);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one tick and hold it until the block takes it.
  task automatic send_tick(logic [7:0] dt, logic alarm, logic clr, logic sload,
                           logic [7:0] scount);
    int unsigned gap;
    gap = idling_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    elapsed_cycles_i <= dt;
    alarm_event_i <= alarm;
    clear_flags_i <= clr;
    serial_load_i <= sload;
    serial_count_i <= scount;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_tick(dt, alarm, clr, sload, scount);
  endtask

  task automatic send_random_tick();
    logic [7:0]  dt;
    logic [7:0]  scount;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) dt = 8'($urandom_range(0, 8));
    else if (r < 9) dt = 8'($urandom_range(0, 255));
    else dt = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    scount = $urandom_range(0, 1) ? 8'($urandom_range(1, 6)) : 8'($urandom_range(0, 255));
    send_tick(dt, $urandom_range(0, 4) == 0, $urandom_range(0, 3) == 0,
              $urandom_range(0, 4) == 0, scount);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_config(int unsigned phase);
    logic [7:0]  ca, cb;
    int unsigned r;
    if (phase == 0) begin
      program_regs(8'hFF, 8'hFF, 5'h1F, 16'hFFFF, 16'hFFFF);
    end else if (phase == 1) begin
      program_regs('0, '0, '0, '0, '0);
    end else begin
      ca = 8'($urandom_range(0, 255));
      ca[CtlStart] = $urandom_range(0, 6) != 0;
      ca[CtlCntSrc] = $urandom_range(0, 9) == 0;
      cb = 8'($urandom_range(0, 255));
      cb[CtlStart] = $urandom_range(0, 6) != 0;
      r = $urandom_range(0, 19);
      if (r < 9) cb[CtlSerial:CtlCntSrc] = SrcCycles;
      else if (r < 16) cb[CtlSerial:CtlCntSrc] = SrcChained;
      else if (r < 18) cb[CtlSerial:CtlCntSrc] = SrcCntPulses;
      else cb[CtlSerial:CtlCntSrc] = SrcCntChained;
      program_regs(ca, cb, 5'($urandom_range(0, 31)), pick_reload(), pick_reload());
    end
  endtask

  task automatic run_directed();
    // Timers stopped: flag clear, masked alarm, serial load straight in,
    // then a pending count of zero replaced by a nonzero one.
    send_tick(8'h00, 1'b0, 1'b1, 1'b0, 8'h00);
    send_tick(8'hFF, 1'b1, 1'b0, 1'b1, 8'd5);
    send_tick(8'h00, 1'b0, 1'b0, 1'b1, 8'h00);
    send_tick(8'h01, 1'b0, 1'b0, 1'b1, 8'd3);
    drain();
    // Timer B one-shot at zero keeps signaling; alarm raises irq when enabled.
    program_regs('0, ctl_word(1'b1, 1'b1, 1'b0, 1'b1, SrcCycles), 5'h1F, '0, 16'hFFFF);
    send_tick(8'h00, 1'b0, 1'b0, 1'b0, 8'h00);
    send_tick(8'h00, 1'b1, 1'b1, 1'b0, 8'h00);
    drain();
    // Chained with no timer A underflow: count stays at zero and still signals.
    program_regs('0, ctl_word(1'b1, 1'b1, 1'b0, 1'b1, SrcChained), 5'h1F, '0, 16'hFFFF);
    send_tick(8'd17, 1'b0, 1'b1, 1'b0, 8'h00);
    drain();
    // Timer A reloading zero underflows every tick and walks the serial
    // counter down to zero; chained timer B wraps from zero.
    program_regs(ctl_word(1'b1, 1'b1, 1'b0, 1'b0, 2'b10),
                 ctl_word(1'b1, 1'b1, 1'b0, 1'b0, SrcChained), 5'h0F, '0, 16'd1);
    repeat (6) send_tick(8'h00, 1'b0, 1'b0, 1'b0, 8'h00);
    send_tick(8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF);
    drain();
    // Pulse mode does not toggle; one-shot A stays at zero; B on a CNT source.
    program_regs(ctl_word(1'b1, 1'b1, 1'b1, 1'b1, 2'b00),
                 ctl_word(1'b1, 1'b1, 1'b0, 1'b0, SrcCntPulses), 5'h01, 16'd4, 16'd2);
    send_tick(8'd4, 1'b0, 1'b1, 1'b0, 8'h00);
    send_tick(8'd4, 1'b0, 1'b0, 1'b0, 8'h00);
    drain();
    // Timer A halted keeps its underflow note for chained timer B.
    program_regs(ctl_word(1'b1, 1'b0, 1'b0, 1'b0, 2'b01),
                 ctl_word(1'b1, 1'b0, 1'b0, 1'b0, SrcChained), 5'h02, '0, 16'd2);
    send_tick(8'd9, 1'b0, 1'b1, 1'b0, 8'h00);
    send_tick(8'd9, 1'b0, 1'b0, 1'b0, 8'h00);
    drain();
    program_regs('0, ctl_word(1'b1, 1'b1, 1'b0, 1'b0, SrcCntChained), 5'h1F, '0, '0);
    send_tick(8'd3, 1'b1, 1'b0, 1'b0, 8'h00);
    drain();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0)
        sb.check_outcome(irq_o, flag_latch_o, port_b6_o, port_b7_o);
      if ((in_valid_i && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, quiet stretches and one long hold-off.
  initial begin : result_sink
    bit stalling;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (!idling_on) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        stalling = $urandom_range(0, 3) == 0;
        out_stall_i <= stalling;
        repeat (stalling ? 1 + pick_gap() : $urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    wait (rst_ni === 1'b1);
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("%0t ERROR: no item moved for %0d cycles", $time, WatchdogLimit);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    elapsed_cycles_i <= '0;
    alarm_event_i <= 1'b0;
    clear_flags_i <= 1'b0;
    serial_load_i <= 1'b0;
    serial_count_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (phase = 0; phase < NumPhases; phase++) begin
      random_config(phase);
      idling_on = (phase == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      // The sink holds off while ticks keep coming, so the block backs up.
      if (phase == 4) hold_off_req = 1'b1;
      repeat (ItemsPerPhase) send_random_tick();
      drain();
    end
    repeat (EndSettle) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/dit_pkg.sv
design/dual_interval_timer_irq.sv
dv/dual_interval_timer_irq_tb.sv
